### sv/ordered_knn_neighbor_search_unit_macros.svh
// Assertion macros for the neighbor search block.
`ifndef ORDERED_KNN_NEIGHBOR_SEARCH_UNIT_MACROS_SVH
`define ORDERED_KNN_NEIGHBOR_SEARCH_UNIT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define OKNN_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence in the following cycle.
`define OKNN_ASSERT_NEXT(lbl, cond, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (cons)) \
		else $error(msg);

`endif

### sv/oknn_pkg.sv
package oknn_pkg;
	localparam int MAX_POINTS = 1024;
	localparam int ADDR_W     = $clog2(MAX_POINTS);
	localparam int CNT_W      = $clog2(MAX_POINTS + 1);
	localparam int MAX_K      = 16;
	localparam int K_W        = 5;
	localparam int RANK_W     = 4;
	localparam int FILL_W     = $clog2(MAX_K + 1);
	localparam int COORD_W    = 16;
	localparam int VAL_W      = 32;
	localparam int SQ_W       = 34;
	localparam int DIST_W     = 25;
	localparam int IDX_W      = 11;
	localparam int WORD_W     = 2 * COORD_W + VAL_W;
	localparam int REM_W      = DIST_W + 1;
	localparam int RAD_W      = SQ_W + 16;
	localparam logic [K_W-1:0] K_RESET = 5'd10;
endpackage

### sv/ordered_knn_neighbor_search_unit.sv
// Channel | Direction | Handshake        | Payload
// s_axis  | in        | tvalid/tready    | tdata {obs_value,coord_y,coord_x}, tuser mode
// m_axis  | out       | tvalid/tready    | tdata {value,distance,index,rank},
//         |           |                  | tuser {overflow,found}, tlast last
// cfg     | in        | cfg_wr_en        | cfg_wr_data num_neighbors
// One item at a time: the n stored points are scanned through the
// single-port point memory and its three-stage distance pipeline, then each
// result takes a value read and a bit-serial square root.
// Reset clears the point count and control; memory contents are not cleared.
// A stalled result holds in the output register; the next item is taken then.
`include "ordered_knn_neighbor_search_unit_macros.svh"

module ordered_knn_neighbor_search_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,   // coord_x[15:0], coord_y[31:16], obs_value[63:32]
	input  logic        s_axis_tuser,   // mode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata,   // rank[3:0], neighbor_index[14:4],
	                                    // distance[39:15], neighbor_value[71:40]
	output logic [1:0]  m_axis_tuser,   // found[0], overflow[1]
	output logic        m_axis_tlast,
	input  logic        cfg_wr_en,
	input  logic [4:0]  cfg_wr_data
);
	localparam int AW = oknn_pkg::ADDR_W;
	localparam int CW = oknn_pkg::CNT_W;
	localparam int KN = oknn_pkg::MAX_K;
	localparam int FW = oknn_pkg::FILL_W;
	localparam int SW = oknn_pkg::SQ_W;
	localparam int CD = oknn_pkg::COORD_W;
	localparam int VW = oknn_pkg::VAL_W;
	localparam int DW = oknn_pkg::DIST_W;
	localparam int RW = oknn_pkg::REM_W;

	typedef enum logic [2:0] {
		ST_IDLE, ST_SCAN, ST_DRAIN, ST_STORE, ST_RDVAL, ST_SQRT, ST_EMIT
	} state_t;

	state_t state_q;
	logic [oknn_pkg::WORD_W-1:0] mem [oknn_pkg::MAX_POINTS];
	logic [oknn_pkg::WORD_W-1:0] rdata_q;
	logic [AW-1:0] raddr_c;
	logic          wen_c;

	logic [oknn_pkg::K_W-1:0] cfg_k_q;
	logic [FW-1:0] k_q, filled_q;
	logic [CW-1:0] count_q, n_q, j_q;
	logic          mode_q, ovf_q;
	logic signed [CD-1:0] px_q, py_q;
	logic [VW-1:0] pval_q;

	logic [SW-1:0] best_sq_q [KN];
	logic [AW-1:0] best_idx_q [KN];

	logic          rd_v_s1, sq_v_s2, sum_v_s3;
	logic [AW-1:0] idx_s1, idx_s2, idx_s3;
	logic [SW-2:0] sqx_s2, sqy_s2;
	logic [SW-1:0] sum_s3;

	logic [oknn_pkg::RANK_W-1:0] r_q;
	logic [oknn_pkg::RAD_W-1:0]  rad_q;
	logic [RW-1:0] rem_q;
	logic [DW-1:0] root_q;
	logic [4:0]    it_q;
	logic [VW-1:0] val_q;

	logic          out_v_q;
	logic [71:0]   out_d_q;
	logic [1:0]    out_u_q;
	logic          out_l_q;

	logic signed [CD:0] dx_c, dy_c;
	logic signed [2*CD+1:0] mx_c, my_c;
	logic [KN-1:0] lt_c;
	logic [RW+1:0] rem_sh_c;
	logic [DW+1:0] trial_c;
	logic [CW-1:0] j_next_c;
	logic [FW-1:0] r_ext_c;

	function automatic logic [oknn_pkg::IDX_W-1:0] IDX_PAD(input logic [AW-1:0] idx);
		IDX_PAD = oknn_pkg::IDX_W'(idx) + oknn_pkg::IDX_W'(1);
	endfunction

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = out_d_q;
	assign m_axis_tuser  = out_u_q;
	assign m_axis_tlast  = out_l_q;

	assign dx_c = {px_q[CD-1], px_q} - {rdata_q[CD-1], rdata_q[CD-1:0]};
	assign dy_c = {py_q[CD-1], py_q} - {rdata_q[2*CD-1], rdata_q[2*CD-1:CD]};
	assign mx_c = dx_c * dx_c;
	assign my_c = dy_c * dy_c;
	assign j_next_c = j_q + CW'(1);
	assign r_ext_c  = FW'(r_q);

	assign rem_sh_c = {rem_q, rad_q[oknn_pkg::RAD_W-1 -: 2]};
	assign trial_c  = {root_q, 2'b01};

	always_comb begin
		raddr_c = j_q[AW-1:0];
		if (state_q == ST_RDVAL) begin
			raddr_c = best_idx_q[r_q];
		end
		wen_c = (state_q == ST_STORE) && (mode_q == 1'b0) && !ovf_q;
	end

	always_comb begin
		for (int i = 0; i < KN; i++) begin
			lt_c[i] = (FW'(i) >= filled_q) || (sum_s3 < best_sq_q[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (wen_c) begin
			mem[n_q[AW-1:0]] <= {pval_q, py_q, px_q};
		end else begin
			rdata_q <= mem[raddr_c];
		end
	end

	always_ff @(posedge clk) begin
		if (sum_v_s3 && ((filled_q < k_q) || lt_c[4'(k_q - FW'(1))])) begin
			for (int i = 0; i < KN; i++) begin
				if (FW'(i) < k_q && lt_c[i]) begin
					if (i == 0) begin
						best_sq_q[i]  <= sum_s3;
						best_idx_q[i] <= idx_s3;
					end else if (!lt_c[(i == 0) ? 0 : i - 1]) begin
						best_sq_q[i]  <= sum_s3;
						best_idx_q[i] <= idx_s3;
					end else begin
						best_sq_q[i]  <= best_sq_q[(i == 0) ? 0 : i - 1];
						best_idx_q[i] <= best_idx_q[(i == 0) ? 0 : i - 1];
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= j_q[AW-1:0];
		idx_s2 <= idx_s1;
		idx_s3 <= idx_s2;
		sqx_s2 <= mx_c[SW-2:0];
		sqy_s2 <= my_c[SW-2:0];
		sum_s3 <= {1'b0, sqx_s2} + {1'b0, sqy_s2};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_s1  <= 1'b0;
			sq_v_s2  <= 1'b0;
			sum_v_s3 <= 1'b0;
		end else begin
			rd_v_s1  <= (state_q == ST_SCAN);
			sq_v_s2  <= rd_v_s1;
			sum_v_s3 <= sq_v_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_k_q <= oknn_pkg::K_RESET;
		end else if (cfg_wr_en) begin
			cfg_k_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			filled_q <= '0;
			out_v_q  <= 1'b0;
			k_q      <= '0;
			n_q      <= '0;
			j_q      <= '0;
			r_q      <= '0;
			it_q     <= '0;
			mode_q   <= 1'b0;
			ovf_q    <= 1'b0;
		end else begin
			if (out_v_q && m_axis_tready && state_q != ST_EMIT) begin
				out_v_q <= 1'b0;
			end
			if (sum_v_s3 && filled_q < k_q) begin
				filled_q <= filled_q + FW'(1);
			end
			case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						px_q     <= s_axis_tdata[CD-1:0];
						py_q     <= s_axis_tdata[2*CD-1:CD];
						pval_q   <= s_axis_tdata[63:2*CD];
						mode_q   <= s_axis_tuser;
						ovf_q    <= !s_axis_tuser && (count_q == CW'(oknn_pkg::MAX_POINTS));
						n_q      <= count_q;
						j_q      <= '0;
						filled_q <= '0;
						r_q      <= '0;
						if (cfg_k_q == '0) begin
							k_q <= FW'(1);
						end else if (FW'(cfg_k_q) > FW'(KN)) begin
							k_q <= FW'(KN);
						end else begin
							k_q <= FW'(cfg_k_q);
						end
						state_q <= (count_q == '0) ? ST_DRAIN : ST_SCAN;
					end
				end
				ST_SCAN: begin
					j_q <= j_next_c;
					if (j_next_c == n_q) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!rd_v_s1 && !sq_v_s2 && !sum_v_s3) begin
						state_q <= ST_STORE;
					end
				end
				ST_STORE: begin
					if (wen_c) begin
						count_q <= n_q + CW'(1);
					end
					state_q <= (filled_q == '0) ? ST_EMIT : ST_RDVAL;
				end
				ST_RDVAL: begin
					rad_q   <= {best_sq_q[r_q], 16'b0};
					rem_q   <= '0;
					root_q  <= '0;
					it_q    <= '0;
					state_q <= ST_SQRT;
				end
				ST_SQRT: begin
					if (it_q == '0) begin
						val_q <= rdata_q[oknn_pkg::WORD_W-1 -: VW];
					end
					rad_q <= rad_q << 2;
					if (rem_sh_c >= trial_c) begin
						rem_q  <= RW'(rem_sh_c - trial_c);
						root_q <= {root_q[DW-2:0], 1'b1};
					end else begin
						rem_q  <= RW'(rem_sh_c);
						root_q <= {root_q[DW-2:0], 1'b0};
					end
					it_q <= it_q + 5'd1;
					if (it_q == 5'(DW - 1)) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (!out_v_q || m_axis_tready) begin
						out_v_q <= 1'b1;
						if (filled_q == '0) begin
							out_d_q <= '0;
							out_u_q <= {ovf_q, 1'b0};
							out_l_q <= 1'b1;
							state_q <= ST_IDLE;
						end else begin
							out_d_q <= {val_q, root_q,
								IDX_PAD(best_idx_q[r_q]), r_q};
							out_u_q <= {ovf_q, 1'b1};
							out_l_q <= (r_ext_c + FW'(1) == filled_q);
							r_q     <= r_q + 1'b1;
							state_q <= (r_ext_c + FW'(1) == filled_q) ? ST_IDLE : ST_RDVAL;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`OKNN_ASSERT(a_fill_le_k, filled_q <= k_q, "candidate list exceeds K")
	`OKNN_ASSERT(a_count_cap, count_q <= CW'(oknn_pkg::MAX_POINTS), "point count beyond capacity")
	`OKNN_ASSERT_NEXT(a_store_inc, wen_c, count_q == $past(count_q) + CW'(1),
		"store did not advance count")
	`OKNN_ASSERT(a_pipe_scan, !sum_v_s3 || state_q == ST_SCAN || state_q == ST_DRAIN,
		"distance pipeline busy outside scan")
endmodule
